@@ rtl/core/sis_pkg.sv @@
// Shared constants, codes and the result record of the sorted integer set.
package sis_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_REMOVE   = 2'd1,
        MODE_CONTAINS = 2'd2,
        MODE_CLEAR    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_ADDED   = 3'd0,
        STAT_PRESENT = 3'd1,
        STAT_REMOVED = 3'd2,
        STAT_ABSENT  = 3'd3,
        STAT_FOUND   = 3'd4,
        STAT_CLEARED = 3'd5,
        STAT_FULL    = 3'd6
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   position;
        logic [CNT_W-1:0]   entry_total;
    } result_t;

endpackage

@@ rtl/core/sis_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

@@ rtl/core/sis_seq.sv @@
// Sequencer of the sorted integer set: binary search, hit check and entry shifting.
module sis_seq import sis_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_mode,
    input  logic [KEY_WIDTH-1:0]  in_key,
    output logic                  res_valid,
    input  logic                  res_free,
    output result_t               result,
    output logic                  ram_wr_en,
    output logic [IDX_W-1:0]      ram_wr_addr,
    output logic [KEY_WIDTH-1:0]  ram_wr_data,
    output logic [IDX_W-1:0]      ram_rd_addr,
    input  logic [KEY_WIDTH-1:0]  ram_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_PROBE, S_CMP, S_HIT, S_UP, S_INS, S_DOWN, S_DONE
    } state_t;

    state_t                state_reg,  state_next;
    mode_t                 mode_reg,   mode_next;
    logic [KEY_WIDTH-1:0]  key_reg,    key_next;
    logic [CNT_W-1:0]      lo_reg,     lo_next;
    logic [CNT_W-1:0]      hi_reg,     hi_next;
    logic [CNT_W-1:0]      cnt_reg,    cnt_next;
    logic [CNT_W-1:0]      ptr_reg,    ptr_next;
    logic                  wpend_reg,  wpend_next;
    logic [CNT_W-1:0]      wdst_reg,   wdst_next;
    status_t               status_reg, status_next;

    logic [CNT_W-1:0] mid;
    logic             key_below;
    logic             hit;

    // Signed less-than compare: the probed entry against the search key.
    assign key_below = $signed(ram_rd_data) < $signed(key_reg);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign hit       = (lo_reg < cnt_reg) && (ram_rd_data == key_reg);

    assign result.status      = status_reg;
    assign result.position    = lo_reg;
    assign result.entry_total = cnt_reg;

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        key_next    = key_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        wpend_next  = wpend_reg;
        wdst_next   = wdst_reg;
        status_next = status_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wdst_reg[IDX_W-1:0];
        ram_wr_data = ram_rd_data;
        ram_rd_addr = '0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    mode_next = mode_t'(in_mode);
                    key_next  = in_key;
                    lo_next   = '0;
                    hi_next   = cnt_reg;
                    if (mode_t'(in_mode) == MODE_CLEAR) begin
                        cnt_next    = '0;
                        status_next = STAT_CLEARED;
                        state_next  = S_DONE;
                    end else begin
                        state_next  = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (lo_reg < hi_reg) begin
                    ram_rd_addr = mid[IDX_W-1:0];
                    state_next  = S_CMP;
                end else begin
                    ram_rd_addr = lo_reg[IDX_W-1:0];
                    state_next  = S_HIT;
                end
            end
            S_CMP: begin
                if (key_below) begin
                    lo_next = mid + CNT_W'(1);
                end else begin
                    hi_next = mid;
                end
                state_next = S_PROBE;
            end
            S_HIT: begin
                state_next = S_DONE;
                case (mode_reg)
                    MODE_ADD: begin
                        if (hit) begin
                            status_next = STAT_PRESENT;
                        end else if (cnt_reg == CNT_W'(CAPACITY)) begin
                            status_next = STAT_FULL;
                        end else begin
                            status_next = STAT_ADDED;
                            ptr_next    = cnt_reg;
                            wpend_next  = 1'b0;
                            state_next  = S_UP;
                        end
                    end
                    MODE_REMOVE: begin
                        if (hit) begin
                            status_next = STAT_REMOVED;
                            ptr_next    = lo_reg + CNT_W'(1);
                            wpend_next  = 1'b0;
                            state_next  = S_DOWN;
                        end else begin
                            status_next = STAT_ABSENT;
                        end
                    end
                    default: begin
                        status_next = hit ? STAT_FOUND : STAT_ABSENT;
                    end
                endcase
            end
            S_UP: begin
                // Read the entry below the cursor while writing the one read last cycle.
                ram_wr_en = wpend_reg;
                if (ptr_reg > lo_reg) begin
                    ram_rd_addr = ptr_reg[IDX_W-1:0] - IDX_W'(1);
                    wpend_next  = 1'b1;
                    wdst_next   = ptr_reg;
                    ptr_next    = ptr_reg - CNT_W'(1);
                end else begin
                    wpend_next  = 1'b0;
                    state_next  = S_INS;
                end
            end
            S_INS: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = lo_reg[IDX_W-1:0];
                ram_wr_data = key_reg;
                cnt_next    = cnt_reg + CNT_W'(1);
                state_next  = S_DONE;
            end
            S_DOWN: begin
                ram_wr_en = wpend_reg;
                if (ptr_reg < cnt_reg) begin
                    ram_rd_addr = ptr_reg[IDX_W-1:0];
                    wpend_next  = 1'b1;
                    wdst_next   = ptr_reg - CNT_W'(1);
                    ptr_next    = ptr_reg + CNT_W'(1);
                end else begin
                    wpend_next  = 1'b0;
                    cnt_next    = cnt_reg - CNT_W'(1);
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (res_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            wpend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            wpend_reg <= wpend_next;
        end
        mode_reg   <= mode_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        ptr_reg    <= ptr_next;
        wdst_reg   <= wdst_next;
        status_reg <= status_next;
    end

endmodule

@@ rtl/core/sorted_integer_set_top.sv @@
// Top level of the sorted integer set: key store, sequencer and result register.
//
// The block keeps a set of up to 64 distinct signed 32-bit keys in ascending
// order in a single simple dual-port RAM. Each input word carries a mode and a
// key and yields exactly one result word. One item is handled at a time and
// s_ready is low while it is worked on. A clear skips the search and goes
// straight to the result. Any other mode first runs a binary search over the n
// keys held, each probe an address step and then a compare on the registered
// read data, then reads the entry at the found place and decides. An add then
// shifts the larger entries up and a remove shifts them down, one entry per
// cycle through the RAM's read and write ports. The RAM port is the limit: one
// entry is read and one written per cycle. The result word is held in an
// output register, so the next item is accepted while a result waits; a new
// result is only loaded once the previous one has been taken. An add to a
// full store is refused with the full status. The entry at the end of a search
// may lie at or above the current count and so be unwritten, but it never
// decides a result, as a hit also needs the place to lie below the count.
module sorted_integer_set_top import sis_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic signed [KEY_WIDTH-1:0] s_key,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_status,
    output logic [CNT_W-1:0]      m_position,
    output logic [CNT_W-1:0]      m_entry_total
);

    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    logic [KEY_WIDTH-1:0]  ram_wr_data;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [KEY_WIDTH-1:0]  ram_rd_data;

    logic                  res_valid;
    logic                  res_free;
    result_t               result;

    logic                  m_valid_reg, m_valid_next;
    result_t               m_word_reg;

    // The key store itself.
    sis_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The sequencer drives the search and the shifting of entries.
    sis_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_mode     (s_mode),
        .in_key      (s_key),
        .res_valid   (res_valid),
        .res_free    (res_free),
        .result      (result),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // The output register is free when empty or when its word is taken now.
    assign res_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (res_valid) begin
            m_word_reg <= result;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_word_reg.status;
    assign m_position    = m_word_reg.position;
    assign m_entry_total = m_word_reg.entry_total;

endmodule

@@ dv/sorted_integer_set_checker.sv @@
// Checker for the sorted integer set: watches both channels, predicts and compares result words.
`timescale 1ns / 100ps

module sorted_integer_set_checker import sis_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic signed [KEY_WIDTH-1:0] s_key,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [2:0]                  m_status,
    input  logic [CNT_W-1:0]            m_position,
    input  logic [CNT_W-1:0]            m_entry_total,
    output int unsigned                 fail_count,
    output int unsigned                 pending
);

    // Shadow copy of the set, kept in ascending signed order.
    logic signed [KEY_WIDTH-1:0] shadow_keys [CAPACITY];
    int                          shadow_count;
    result_t                     awaited_results [$];
    int unsigned                 errors;

    initial begin
        errors = 0;
    end

    // First index whose key is not below k.
    function automatic int lower_bound(input logic signed [KEY_WIDTH-1:0] k);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] < k) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Applies one input word to the shadow set and returns the result word it yields.
    function automatic result_t apply_to_set(input mode_t mode,
                                             input logic signed [KEY_WIDTH-1:0] key);
        result_t r;
        int      place;
        int      i;
        bit      hit;
        r.position = '0;
        if (mode == MODE_CLEAR) begin
            shadow_count = 0;
            r.status     = STAT_CLEARED;
        end else begin
            place      = lower_bound(key);
            hit        = (place < shadow_count) && (shadow_keys[place] == key);
            r.position = CNT_W'(place);
            case (mode)
                MODE_ADD: begin
                    if (hit) begin
                        r.status = STAT_PRESENT;
                    end else if (shadow_count >= CAPACITY) begin
                        r.status = STAT_FULL;
                    end else begin
                        for (i = shadow_count; i > place; i--) begin
                            shadow_keys[i] = shadow_keys[i-1];
                        end
                        shadow_keys[place] = key;
                        shadow_count++;
                        r.status = STAT_ADDED;
                    end
                end
                MODE_REMOVE: begin
                    if (hit) begin
                        for (i = place; i + 1 < shadow_count; i++) begin
                            shadow_keys[i] = shadow_keys[i+1];
                        end
                        shadow_count--;
                        r.status = STAT_REMOVED;
                    end else begin
                        r.status = STAT_ABSENT;
                    end
                end
                default: begin
                    r.status = hit ? STAT_FOUND : STAT_ABSENT;
                end
            endcase
        end
        r.entry_total = CNT_W'(shadow_count);
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            // A result word can never belong to the input word taken at the same edge.
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with nothing awaited: status %0d position %0d total %0d",
                           m_status, m_position, m_entry_total);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d", want.status, m_status);
                        errors++;
                    end
                    if (m_position !== want.position) begin
                        $error("position mismatch: expected %0d, got %0d",
                               want.position, m_position);
                        errors++;
                    end
                    if (m_entry_total !== want.entry_total) begin
                        $error("entry_total mismatch: expected %0d, got %0d",
                               want.entry_total, m_entry_total);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(apply_to_set(mode_t'(s_mode), s_key));
            end
        end
        fail_count <= errors;
        pending    <= awaited_results.size();
    end

endmodule

@@ dv/testbench.sv @@
// Top of the sorted integer set testbench: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 100ps

module testbench import sis_pkg::*; ();

    // Number of random input words after the directed part.
    localparam int RANDOM_WORDS = 1425;
    // Ring of recently added keys, larger than the store so removes also miss.
    localparam int POOL_SIZE    = 96;
    // Length of the single long hold-off on the result side.
    localparam int HOLD_CYCLES  = 600;
    // Words sent before the long hold-off starts.
    localparam int HOLD_AFTER   = 300;
    // Cycles allowed after the last result word, well past the block's latency.
    localparam int SETTLE_CYCLES = 200;
    // Cut-off for the run of roughly 1450 words plus gaps and stalls, with a wide margin.
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef enum int {
        ROUND_FILL,
        ROUND_CHURN,
        ROUND_DRAIN,
        ROUND_PROBE
    } round_kind_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_valid;
    logic                        s_ready;
    logic [1:0]                  s_mode;
    logic signed [KEY_WIDTH-1:0] s_key;
    logic                        m_valid;
    logic                        m_ready;
    logic [2:0]                  m_status;
    logic [CNT_W-1:0]            m_position;
    logic [CNT_W-1:0]            m_entry_total;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count;
    int unsigned words_sent;
    bit          hold_done;
    bit          quiet;

    logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
    int                   pool_fill;
    int                   pool_head;

    localparam logic [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
    localparam logic [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};

    sorted_integer_set_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_position    (m_position),
        .m_entry_total (m_entry_total)
    );

    sorted_integer_set_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_position    (m_position),
        .m_entry_total (m_entry_total),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The run is cut off here if the block ever stops answering.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Keys are drawn fresh, from the extremes, or from keys added before, so
    // that hits and misses both occur; a neighbour of a known key lands
    // between held entries.
    function automatic logic [KEY_WIDTH-1:0] pick_key(input int fresh_pct);
        int                   r;
        logic [KEY_WIDTH-1:0] k;
        r = $urandom_range(0, 99);
        if (pool_fill == 0 || r < fresh_pct) begin
            k = $urandom;
        end else if (r < fresh_pct + 5) begin
            case ($urandom_range(0, 3))
                0:       k = KEY_MIN;
                1:       k = KEY_MAX;
                2:       k = '0;
                default: k = '1;
            endcase
        end else begin
            k = key_pool[$urandom_range(0, pool_fill - 1)];
            if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, 1) ? k + KEY_WIDTH'(1) : k - KEY_WIDTH'(1);
            end
        end
        return k;
    endfunction

    // Offers one input word and waits until it is taken. Valid is only ever
    // assigned once per edge: it is lowered for a gap, or simply kept high
    // when the next word follows straight away.
    task automatic offer_word(input mode_t mode, input logic [KEY_WIDTH-1:0] key);
        int gap;
        gap = quiet ? 0 : idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (mode == MODE_ADD) begin
            key_pool[pool_head] = key;
            pool_head = (pool_head + 1) % POOL_SIZE;
            if (pool_fill < POOL_SIZE) begin
                pool_fill++;
            end
        end
    endtask

    // Result side: stretches of ready with random idle gaps between them, and
    // once a long hold-off so that the output register fills, the block
    // finishes the word behind it and then has to refuse further input.
    initial begin : result_sink
        int stretch;
        m_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && words_sent >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            m_ready <= 1'b1;
            repeat (stretch) @(posedge aclk);
            stretch = idle_cycles();
            if (stretch > 0) begin
                m_ready <= 1'b0;
                repeat (stretch) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        round_kind_t kind;
        mode_t       mode;
        int          round;
        int          len;
        int          n;
        int          r;
        int          random_sent;
        int          fresh_pct;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_mode     = MODE_ADD;
        s_key      = '0;
        words_sent = 0;
        quiet      = 1'b0;
        pool_fill  = 0;
        pool_head  = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: operations on the empty set, the extreme keys, a
        // duplicate add, hits and misses at both ends and in the middle,
        // removes at each end, a clear whose key is ignored, and keys with
        // alternating bit patterns.
        offer_word(MODE_CONTAINS, '0);
        offer_word(MODE_REMOVE,   KEY_WIDTH'(5));
        offer_word(MODE_CLEAR,    '0);
        offer_word(MODE_ADD,      '0);
        offer_word(MODE_ADD,      KEY_MIN);
        offer_word(MODE_ADD,      KEY_MAX);
        offer_word(MODE_ADD,      '1);
        offer_word(MODE_ADD,      KEY_WIDTH'(1));
        offer_word(MODE_ADD,      '0);
        offer_word(MODE_CONTAINS, KEY_MIN);
        offer_word(MODE_CONTAINS, KEY_MAX);
        offer_word(MODE_CONTAINS, KEY_WIDTH'(2));
        offer_word(MODE_CONTAINS, KEY_MIN + KEY_WIDTH'(1));
        offer_word(MODE_CONTAINS, KEY_MAX - KEY_WIDTH'(1));
        offer_word(MODE_REMOVE,   KEY_MAX);
        offer_word(MODE_REMOVE,   KEY_MIN);
        offer_word(MODE_REMOVE,   '0);
        offer_word(MODE_REMOVE,   '0);
        offer_word(MODE_CLEAR,    '1);
        offer_word(MODE_CONTAINS, '1);
        offer_word(MODE_ADD,      {(KEY_WIDTH/2){2'b10}});
        offer_word(MODE_ADD,      {(KEY_WIDTH/2){2'b01}});
        offer_word(MODE_CONTAINS, {(KEY_WIDTH/2){2'b10}});

        // Random part in rounds. The first round fills the store so that
        // adds to a full set, and adds of keys already held while full, come
        // early; later rounds mix churn, draining and lookups, with the odd
        // clear to start over.
        random_sent = 0;
        round       = 0;
        while (random_sent < RANDOM_WORDS) begin
            if (round == 0) begin
                kind = ROUND_FILL;
            end else begin
                kind = round_kind_t'($urandom_range(0, 3));
            end
            quiet = ($urandom_range(0, 3) == 0);
            len   = (kind == ROUND_FILL) ? 110 : $urandom_range(40, 120);
            for (n = 0; n < len && random_sent < RANDOM_WORDS; n++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    ROUND_FILL: begin
                        fresh_pct = 60;
                        mode = (r < 85) ? MODE_ADD : (r < 95) ? MODE_CONTAINS : MODE_REMOVE;
                    end
                    ROUND_CHURN: begin
                        fresh_pct = 30;
                        mode = (r < 36) ? MODE_ADD : (r < 67) ? MODE_REMOVE :
                               (r < 99) ? MODE_CONTAINS : MODE_CLEAR;
                    end
                    ROUND_DRAIN: begin
                        fresh_pct = 10;
                        mode = (r < 70) ? MODE_REMOVE : (r < 85) ? MODE_CONTAINS : MODE_ADD;
                    end
                    default: begin
                        fresh_pct = 25;
                        mode = (r < 80) ? MODE_CONTAINS : (r < 90) ? MODE_ADD : MODE_REMOVE;
                    end
                endcase
                offer_word(mode, pick_key(fresh_pct));
                random_sent++;
            end
            if ($urandom_range(0, 5) == 0 && random_sent < RANDOM_WORDS) begin
                offer_word(MODE_CLEAR, $urandom);
                random_sent++;
            end
            round++;
        end
        s_valid <= 1'b0;
        quiet = 1'b0;

        // Let the checker register the last word, then wait for every
        // awaited result word and a settling time beyond it.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
